// ----- design/radix_string_converter_macros.svh -----
// Assertion macros used by the checker file of the radix string converter.
`ifndef RADIX_STRING_CONVERTER_MACROS_SVH
`define RADIX_STRING_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RSC_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RSC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

// Next-cycle implication that is also checked while reset is high.
`define RSC_ASSERT_NEXT_RST(label, cond, prop, msg) \
   label: assert property (@(posedge clock) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- design/rsc_pkg.sv -----
package rsc_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int COUNT_W     = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] UPPER_OFFSET = 8'd55;
   localparam logic [7:0] LOWER_OFFSET = 8'd87;

   typedef enum logic [1:0] {
      RADIX_BIN = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_DEC = 2'd2,
      RADIX_HEX = 2'd3
   } radix_type;

   localparam radix_type OUT_RADIX_RESET = RADIX_DEC;

   // Flags of a finished numeral as it moves from the front to the queue.
   typedef struct packed {
      logic push;
      logic bad;
   } push_type;

   // Head-of-queue status seen by the back end.
   typedef struct packed {
      logic valid;
      logic bad;
   } qstat_type;

   // Maximum number of characters allowed for a numeral in a given radix.
   function automatic logic [COUNT_W-1:0] radix_limit(input logic [1:0] r);
      logic [COUNT_W-1:0] lim;
      case (r)
         RADIX_BIN: lim = 7'd60;
         RADIX_OCT: lim = 7'd21;
         RADIX_DEC: lim = 7'd18;
         RADIX_HEX: lim = 7'd16;
         default:   lim = 7'd16;
      endcase
      return lim;
   endfunction

   // Digit value of a character in bits [3:0]; bit 4 set when it is no digit at all.
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [7:0] t;
      logic [4:0] v;
      t = 8'd0;
      v = 5'b1_0000;
      case (c) inside
         [8'h30:8'h39]: begin
            t = c - ASCII_ZERO;
            v = {1'b0, t[3:0]};
         end
         [8'h41:8'h46]: begin
            t = c - UPPER_OFFSET;
            v = {1'b0, t[3:0]};
         end
         [8'h61:8'h66]: begin
            t = c - LOWER_OFFSET;
            v = {1'b0, t[3:0]};
         end
         default: v = 5'b1_0000;
      endcase
      return v;
   endfunction

   // True when a digit value lies below the base of the radix.
   function automatic logic digit_fits(input logic [3:0] v, input logic [1:0] r);
      logic ok;
      case (r)
         RADIX_BIN: ok = (v < 4'd2);
         RADIX_OCT: ok = (v < 4'd8);
         RADIX_DEC: ok = (v < 4'd10);
         RADIX_HEX: ok = 1'b1;
         default:   ok = 1'b1;
      endcase
      return ok;
   endfunction

endpackage

// ----- design/rsc_channel_if.sv -----
// Character input channel.
interface rsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] digit_char;
   logic [1:0] in_radix;
   logic       is_last;

   modport source (output valid, digit_char, in_radix, is_last, input ready);
   modport sink   (input valid, digit_char, in_radix, is_last, output ready);
endinterface

// Digit output channel.
interface rsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;
   logic       bad_input;

   modport source (output valid, out_char, out_last, bad_input, input ready);
   modport sink   (input valid, out_char, out_last, bad_input, output ready);
endinterface

// ----- design/rsc_front.sv -----
module rsc_front #(
   parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   rsc_req_if.sink                req_if,
   input  logic                   q_full,
   output rsc_pkg::push_type      push,
   output logic [VALUE_WIDTH-1:0] push_value
);

   logic [VALUE_WIDTH-1:0]      acc_ff, acc_in, acc_mul, acc_next;
   logic [rsc_pkg::COUNT_W-1:0] cnt_ff, cnt_in, cnt_inc;
   logic                        err_ff, err_in, err_next;
   logic [4:0]                  dv;
   logic                        bad_char, over, accept;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      dv       = rsc_pkg::digit_value(req_if.digit_char);
      bad_char = dv[4] || !rsc_pkg::digit_fits(dv[3:0], req_if.in_radix);
      cnt_inc  = (cnt_ff == rsc_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
      over     = cnt_inc > rsc_pkg::radix_limit(req_if.in_radix);

      case (req_if.in_radix)
         rsc_pkg::RADIX_BIN: acc_mul = acc_ff << 1;
         rsc_pkg::RADIX_OCT: acc_mul = acc_ff << 3;
         rsc_pkg::RADIX_DEC: acc_mul = (acc_ff << 3) + (acc_ff << 1);
         rsc_pkg::RADIX_HEX: acc_mul = acc_ff << 4;
         default:            acc_mul = acc_ff << 4;
      endcase

      acc_next = bad_char ? acc_ff : acc_mul + VALUE_WIDTH'(dv[3:0]);
      err_next = err_ff || over || bad_char;

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      err_in = err_ff;
      if (accept) begin
         if (req_if.is_last) begin
            acc_in = '0;
            cnt_in = '0;
            err_in = 1'b0;
         end else begin
            acc_in = acc_next;
            cnt_in = cnt_inc;
            err_in = err_next;
         end
      end
   end

   assign push.push  = accept && req_if.is_last;
   assign push.bad   = err_next;
   assign push_value = acc_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         err_ff <= err_in;
      end
   end

endmodule

// ----- design/rsc_queue.sv -----
module rsc_queue #(
   parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsc_pkg::push_type      push,
   input  logic [VALUE_WIDTH-1:0] push_value,
   output logic                   full,
   output rsc_pkg::qstat_type     head,
   output logic [VALUE_WIDTH-1:0] head_value,
   input  logic                   pop
);

   localparam int DEPTH = rsc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
   logic                   bad_mem   [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign do_push    = push.push && !full;
   assign do_pop     = pop && (cnt_ff != '0);
   assign head.valid = (cnt_ff != '0);
   assign head.bad   = bad_mem[rd_ptr_ff];
   assign head_value = value_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         value_mem[wr_ptr_ff] <= push_value;
         bad_mem[wr_ptr_ff]   <= push.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- design/rsc_back.sv -----
module rsc_back #(
   parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsc_pkg::radix_type     out_radix,
   input  rsc_pkg::qstat_type     head,
   input  logic [VALUE_WIDTH-1:0] head_value,
   output logic                   pop,
   rsc_rsp_if.source              rsp_if
);

   localparam int W          = VALUE_WIDTH;
   localparam int ND_BIN     = W;
   localparam int ND_OCT     = (W + 2) / 3;
   localparam int ND_HEX     = (W + 3) / 4;
   localparam int DEC_DIGITS = (W * 1233) / 4096 + 1;
   localparam int BCD_W      = DEC_DIGITS * 4;
   localparam int SR_W       = BCD_W;
   localparam int SH_BIN     = SR_W - ND_BIN;
   localparam int SH_OCT     = SR_W - ND_OCT * 3;
   localparam int SH_HEX     = SR_W - ND_HEX * 4;
   localparam int SH_DEC     = SR_W - BCD_W;
   localparam int REM_W      = $clog2(W + 1);
   localparam int STEP_W     = $clog2(W + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DABBLE = 3'b010,
      ST_EMIT   = 3'b100
   } back_state_type;

   back_state_type         state_ff, state_in;
   rsc_pkg::radix_type     rad_ff, rad_in;
   logic [W-1:0]           bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in, bcd_adj, bcd_shift;
   logic [SR_W-1:0]        sr_ff, sr_in, sr_shift;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   lead_ff, lead_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             char_ff, char_in, digit_char;
   logic                   last_ff, last_in;
   logic                   bad_ff, bad_in;
   logic [3:0]             digit;
   logic [3:0]             nib;
   logic                   out_free;

   assign out_free = !valid_ff || rsp_if.ready;

   // Double dabble: every BCD digit of five or more gets three added before the shift.
   always_comb begin
      nib     = 4'd0;
      bcd_adj = bcd_ff;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         nib = bcd_ff[i*4 +: 4];
         bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
      bcd_shift = {bcd_adj[BCD_W-2:0], bin_ff[W-1]};
   end

   // Most significant remaining digit sits at the top of the shift register.
   always_comb begin
      case (rad_ff)
         rsc_pkg::RADIX_BIN: begin
            digit    = {3'b000, sr_ff[SR_W-1]};
            sr_shift = sr_ff << 1;
         end
         rsc_pkg::RADIX_OCT: begin
            digit    = {1'b0, sr_ff[SR_W-1 -: 3]};
            sr_shift = sr_ff << 3;
         end
         default: begin
            digit    = sr_ff[SR_W-1 -: 4];
            sr_shift = sr_ff << 4;
         end
      endcase
      digit_char = (digit < 4'd10) ? rsc_pkg::ASCII_ZERO + 8'(digit)
                                   : rsc_pkg::UPPER_OFFSET + 8'(digit);
   end

   always_comb begin
      state_in = state_ff;
      rad_in   = rad_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      sr_in    = sr_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      lead_in  = lead_ff;
      valid_in = valid_ff && !rsp_if.ready;
      char_in  = char_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid && head.bad) begin
               if (out_free) begin
                  pop      = 1'b1;
                  valid_in = 1'b1;
                  char_in  = rsc_pkg::ASCII_ZERO;
                  last_in  = 1'b1;
                  bad_in   = 1'b1;
               end
            end else if (head.valid) begin
               pop     = 1'b1;
               rad_in  = out_radix;
               lead_in = 1'b1;
               case (out_radix)
                  rsc_pkg::RADIX_BIN: begin
                     sr_in    = SR_W'(head_value) << SH_BIN;
                     rem_in   = REM_W'(ND_BIN);
                     state_in = ST_EMIT;
                  end
                  rsc_pkg::RADIX_OCT: begin
                     sr_in    = SR_W'(head_value) << SH_OCT;
                     rem_in   = REM_W'(ND_OCT);
                     state_in = ST_EMIT;
                  end
                  rsc_pkg::RADIX_DEC: begin
                     bin_in   = head_value;
                     bcd_in   = '0;
                     step_in  = STEP_W'(W);
                     state_in = ST_DABBLE;
                  end
                  default: begin
                     sr_in    = SR_W'(head_value) << SH_HEX;
                     rem_in   = REM_W'(ND_HEX);
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end

         ST_DABBLE: begin
            bcd_in  = bcd_shift;
            bin_in  = bin_ff << 1;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               sr_in    = SR_W'(bcd_shift) << SH_DEC;
               rem_in   = REM_W'(DEC_DIGITS);
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (lead_ff && (digit == 4'd0) && (rem_ff != REM_W'(1))) begin
               sr_in  = sr_shift;
               rem_in = rem_ff - 1'b1;
            end else if (out_free) begin
               valid_in = 1'b1;
               char_in  = digit_char;
               last_in  = (rem_ff == REM_W'(1));
               bad_in   = 1'b0;
               sr_in    = sr_shift;
               rem_in   = rem_ff - 1'b1;
               lead_in  = 1'b0;
               if (rem_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.out_char  = char_ff;
   assign rsp_if.out_last  = last_ff;
   assign rsp_if.bad_input = bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         lead_ff  <= 1'b0;
         rem_ff   <= '0;
         step_ff  <= '0;
         rad_ff   <= rsc_pkg::OUT_RADIX_RESET;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         lead_ff  <= lead_in;
         rem_ff   <= rem_in;
         step_ff  <= step_in;
         rad_ff   <= rad_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      sr_ff   <= sr_in;
      char_ff <= char_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

endmodule

// ----- design/radix_string_converter.sv -----
// Input: one character transfer per cycle while the numeral queue (two entries) has room.
// Result: one digit transfer per cycle while the consumer is ready, once a numeral is converted;
// binary, octal and hex go straight from the queue to read-out, decimal through a double-dabble pass.
// Leading zero digits are dropped at one per cycle. An invalid numeral yields its single result
// in the cycle after it leaves the queue.
// Synchronous active-high reset clears the accumulator, queue, sequencer and out_radix (decimal).
module radix_string_converter #(
   parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   rsc_req_if.sink    req_if,
   rsc_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   // The front end checks and accumulates characters. When the last character of a numeral
   // arrives, its value and error flag are pushed into a short queue, so the front can take
   // the next numeral while the back end is still emitting digits of the previous one.
   // The back end converts the value: power-of-two radices are read out directly from a
   // left-aligned shift register, decimal first runs a double-dabble pass of one bit per cycle.

   rsc_pkg::radix_type     out_radix_ff, out_radix_in;
   rsc_pkg::push_type      push;
   rsc_pkg::qstat_type     head;
   logic [VALUE_WIDTH-1:0] push_value;
   logic [VALUE_WIDTH-1:0] head_value;
   logic                   q_full;
   logic                   pop;

   // Output radix register. The user must write it only while no numeral is in flight; the block
   // does not itself enforce this. The back end samples it when it takes a numeral from the queue.
   assign out_radix_in = csr_wr_en ? rsc_pkg::radix_type'(csr_wr_data) : out_radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_radix_ff <= rsc_pkg::OUT_RADIX_RESET;
      end else begin
         out_radix_ff <= out_radix_in;
      end
   end

   rsc_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_full     (q_full),
      .push       (push),
      .push_value (push_value)
   );

   rsc_queue #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (push_value),
      .full       (q_full),
      .head       (head),
      .head_value (head_value),
      .pop        (pop)
   );

   // The back end's output register holds a digit until its transfer; while it waits, the next
   // digit is held back, but a new numeral can still be taken and its decimal pass can run.
   rsc_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .out_radix  (out_radix_ff),
      .head       (head),
      .head_value (head_value),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

// ----- design/rsc_checker.sv -----
`include "radix_string_converter_macros.svh"

module rsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_char,
   input logic       out_last,
   input logic       bad_input
);

   `RSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_char) && $stable(out_last) && $stable(bad_input), "stalled result changed")

   `RSC_ASSERT_IMP(a_bad_single, rsp_valid && bad_input, out_last && (out_char == 8'h30), "error result is not a single zero")

   `RSC_ASSERT_IMP(a_digit_set, rsp_valid, ((out_char >= 8'h30) && (out_char <= 8'h39)) || ((out_char >= 8'h41) && (out_char <= 8'h46)), "result is not an upper-case digit")

   `RSC_ASSERT_NEXT_RST(a_reset_idle, reset, !rsp_valid, "result valid after reset")

endmodule

bind radix_string_converter rsc_checker u_rsc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .out_char  (rsp_if.out_char),
   .out_last  (rsp_if.out_last),
   .bad_input (rsp_if.bad_input)
);

// ----- tb/sv/radix_string_converter_checker.sv -----
`timescale 1ns / 100ps

module radix_string_converter_checker (
   input  logic       clock,
   input  logic       reset,
   rsc_req_if         req_mon,
   rsc_rsp_if         rsp_mon,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   output int         outstanding,
   output int         fail_count
);

   localparam logic [6:0] BIN_MAX_CHARS = 7'd60;
   localparam logic [6:0] OCT_MAX_CHARS = 7'd21;
   localparam logic [6:0] DEC_MAX_CHARS = 7'd18;
   localparam logic [6:0] HEX_MAX_CHARS = 7'd16;
   localparam logic [6:0] CHARS_SATURATE = 7'd127;
   localparam int MAX_DIGITS = 64;
   localparam int MAX_PRINTED = 100;
   localparam int VW = rsc_pkg::VALUE_WIDTH;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       bad;
   } out_digit_type;

   out_digit_type digits_due[$];
   out_digit_type due;

   logic [VW-1:0]       value_acc;
   logic [6:0]          chars_seen;
   logic                numeral_bad;
   rsc_pkg::radix_type  emit_radix;
   int                  mismatches;

   function automatic logic [VW-1:0] base_of(input rsc_pkg::radix_type r);
      logic [VW-1:0] b;
      case (r)
         rsc_pkg::RADIX_BIN: b = 2;
         rsc_pkg::RADIX_OCT: b = 8;
         rsc_pkg::RADIX_DEC: b = 10;
         default:            b = 16;
      endcase
      return b;
   endfunction

   function automatic logic [6:0] length_cap(input rsc_pkg::radix_type r);
      logic [6:0] cap;
      case (r)
         rsc_pkg::RADIX_BIN: cap = BIN_MAX_CHARS;
         rsc_pkg::RADIX_OCT: cap = OCT_MAX_CHARS;
         rsc_pkg::RADIX_DEC: cap = DEC_MAX_CHARS;
         default:            cap = HEX_MAX_CHARS;
      endcase
      return cap;
   endfunction

   // Weight of a character in a radix, or -1 when it is no digit of that radix.
   function automatic int char_weight(input logic [7:0] c, input rsc_pkg::radix_type r);
      int v;
      v = -1;
      if (c >= 8'h30 && c <= 8'h39) v = int'(c - rsc_pkg::ASCII_ZERO);
      else if (c >= 8'h41 && c <= 8'h46) v = int'(c - rsc_pkg::UPPER_OFFSET);
      else if (c >= 8'h61 && c <= 8'h66) v = int'(c - rsc_pkg::LOWER_OFFSET);
      if (v >= 0 && v >= int'(base_of(r))) v = -1;
      return v;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t checker: %s", $time, what);
   endtask

   // Folds one character into the numeral and, on the last one, queues the digits due.
   task automatic absorb_char(input logic [7:0] c, input rsc_pkg::radix_type r,
                              input logic last);
      int            w;
      int            n;
      logic [VW-1:0] rest;
      logic [VW-1:0] b;
      logic [7:0]    d;
      logic [7:0]    digits [MAX_DIGITS];
      if (chars_seen != CHARS_SATURATE) chars_seen++;
      if (chars_seen > length_cap(r)) numeral_bad = 1'b1;
      w = char_weight(c, r);
      if (w < 0) numeral_bad = 1'b1;
      else value_acc = value_acc * base_of(r) + VW'(w);
      if (!last) return;
      if (numeral_bad) begin
         digits_due.push_back('{ch: rsc_pkg::ASCII_ZERO, last: 1'b1, bad: 1'b1});
      end else begin
         rest = value_acc;
         b = base_of(emit_radix);
         n = 0;
         do begin
            d = 8'(rest % b);
            digits[n] = (d < 8'd10) ? rsc_pkg::ASCII_ZERO + d : rsc_pkg::UPPER_OFFSET + d;
            n++;
            rest = rest / b;
         end while (rest != 0 && n < MAX_DIGITS);
         for (int k = n - 1; k >= 0; k--) begin
            digits_due.push_back('{ch: digits[k], last: (k == 0), bad: 1'b0});
         end
      end
      value_acc = '0;
      chars_seen = '0;
      numeral_bad = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         digits_due.delete();
         value_acc = '0;
         chars_seen = '0;
         numeral_bad = 1'b0;
         emit_radix = rsc_pkg::OUT_RADIX_RESET;
      end else begin
         if (csr_wr_en) emit_radix = rsc_pkg::radix_type'(csr_wr_data);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (digits_due.size() == 0) begin
               report_mismatch($sformatf("digit 0x%02h arrived with none due",
                                         rsp_mon.out_char));
            end else begin
               due = digits_due.pop_front();
               if (rsp_mon.out_char !== due.ch)
                  report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                            rsp_mon.out_char, due.ch));
               if (rsp_mon.out_last !== due.last)
                  report_mismatch($sformatf("out_last %b, expected %b",
                                            rsp_mon.out_last, due.last));
               if (rsp_mon.bad_input !== due.bad)
                  report_mismatch($sformatf("bad_input %b, expected %b",
                                            rsp_mon.bad_input, due.bad));
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_char(req_mon.digit_char, rsc_pkg::radix_type'(req_mon.in_radix),
                        req_mon.is_last);
      end
      outstanding <= digits_due.size();
      fail_count <= mismatches;
   end

endmodule

// ----- tb/sv/radix_string_converter_tb.sv -----
`timescale 1ns / 100ps

module radix_string_converter_tb;

   // The run is bounded far above the slowest correct run: all the characters sent, numerals
   // of up to 64 output digits each, every digit behind a busy receiver, and the decimal
   // back end's double-dabble pass for each numeral.
   localparam int LIMIT_CYCLES = 300000;
   // Quiet time after the last due digit, covering the longest back-end pass.
   localparam int SETTLE_CYCLES = rsc_pkg::VALUE_WIDTH + 32;
   localparam int CHARS_PER_SEGMENT = 8;
   localparam int SEGMENTS = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       rsp_ready = 1'b0;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;
   int         send_gap_pct;
   int         recv_gap_pct;
   int         outstanding;
   int         fail_count;
   int         cycle_count = 0;
   int         chars_sent = 0;

   // Output radix of each random segment; both extremes appear, and hex twice.
   rsc_pkg::radix_type segment_radix [SEGMENTS] =
      '{rsc_pkg::RADIX_BIN, rsc_pkg::RADIX_HEX, rsc_pkg::RADIX_OCT,
        rsc_pkg::RADIX_DEC, rsc_pkg::RADIX_HEX, rsc_pkg::RADIX_BIN};

   rsc_req_if req_ch ();
   rsc_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_ready;

   radix_string_converter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   radix_string_converter_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls at random according to the current idling mode.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
   end

   // Watchdog: a hung block or a lost digit ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Presents one character and holds it until the block takes the transfer. Valid stays
   // high into the next call when no gap is drawn, so back-to-back transfers occur.
   task automatic send_char(input logic [7:0] c, input rsc_pkg::radix_type r,
                            input logic last);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.digit_char <= c;
      req_ch.in_radix   <= r;
      req_ch.is_last    <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_string(input string s, input rsc_pkg::radix_type r);
      for (int i = 0; i < s.len(); i++) send_char(s[i], r, i == s.len() - 1);
   endtask

   // A valid digit of the radix; letters come in either case.
   function automatic logic [7:0] pick_digit(input rsc_pkg::radix_type r);
      int top;
      int v;
      case (r)
         rsc_pkg::RADIX_BIN: top = 1;
         rsc_pkg::RADIX_OCT: top = 7;
         rsc_pkg::RADIX_DEC: top = 9;
         default:            top = 15;
      endcase
      v = $urandom_range(0, top);
      if (v < 10) return rsc_pkg::ASCII_ZERO + 8'(v);
      if ($urandom_range(0, 1) == 1) return rsc_pkg::UPPER_OFFSET + 8'(v);
      return rsc_pkg::LOWER_OFFSET + 8'(v);
   endfunction

   // Most numerals are well formed with random digits, so the conversion and the
   // output sequencing get exercised; the rest run into the length limit, mix radices
   // (which can also wrap the value), carry one random character, or are pure noise.
   task automatic send_random_numeral();
      int                 kind;
      int                 len;
      int                 bad_pos;
      rsc_pkg::radix_type r;
      rsc_pkg::radix_type cr;
      logic [7:0]         c;
      kind = $urandom_range(0, 99);
      r = rsc_pkg::radix_type'($urandom_range(0, 3));
      if (kind < 55) len = $urandom_range(1, 6);
      else if (kind < 68) len = int'(rsc_pkg::radix_limit(r));
      else if (kind < 76) len = int'(rsc_pkg::radix_limit(r)) + $urandom_range(1, 2);
      else if (kind < 86) len = $urandom_range(2, 20);
      else if (kind < 94) len = $urandom_range(1, 6);
      else len = $urandom_range(1, 4);
      bad_pos = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
         cr = r;
         if (kind >= 76 && kind < 86) begin
            cr = rsc_pkg::radix_type'($urandom_range(0, 3));
            c = pick_digit(cr);
         end else if (kind >= 94) begin
            cr = rsc_pkg::radix_type'($urandom_range(0, 3));
            c = 8'($urandom_range(0, 255));
         end else if (kind >= 86 && i == bad_pos) begin
            c = 8'($urandom_range(0, 255));
         end else begin
            c = pick_digit(cr);
         end
         send_char(c, cr, i == len - 1);
      end
   endtask

   // The sender pauses until every due digit has come back, then waits out the
   // back end, so the block is idle before the next register write.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_out_radix(input rsc_pkg::radix_type r);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int first_char;
      req_ch.valid      <= 1'b0;
      req_ch.digit_char <= 8'h00;
      req_ch.in_radix   <= rsc_pkg::RADIX_BIN;
      req_ch.is_last    <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= rsc_pkg::RADIX_BIN;
      send_gap_pct = 6;
      recv_gap_pct = 56;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed numerals under the reset output radix (decimal): zero, both letter
      // cases, every input radix, a zero value with a leading zero, characters 0x00
      // and 0xFF, digits out of range for their radix, and a mixed-radix numeral.
      send_string("0", rsc_pkg::RADIX_DEC);
      send_string("Ff", rsc_pkg::RADIX_HEX);
      send_string("aA", rsc_pkg::RADIX_HEX);
      send_string("101", rsc_pkg::RADIX_BIN);
      send_string("70", rsc_pkg::RADIX_OCT);
      send_string("9", rsc_pkg::RADIX_DEC);
      send_string("00", rsc_pkg::RADIX_HEX);
      send_char(8'hFF, rsc_pkg::RADIX_HEX, 1'b1);
      send_char(8'h00, rsc_pkg::RADIX_DEC, 1'b0);
      send_char(rsc_pkg::ASCII_ZERO + 8'd1, rsc_pkg::RADIX_DEC, 1'b1);
      send_string("8", rsc_pkg::RADIX_OCT);
      send_string("21", rsc_pkg::RADIX_BIN);
      send_string("G", rsc_pkg::RADIX_HEX);
      send_char(rsc_pkg::UPPER_OFFSET + 8'd15, rsc_pkg::RADIX_HEX, 1'b0);
      send_char(rsc_pkg::ASCII_ZERO + 8'd1, rsc_pkg::RADIX_BIN, 1'b1);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         // Two segments per idling mode: sender mostly busy with a slow receiver,
         // then the reverse, then both sides at full speed.
         case (seg / 2)
            0: begin
               send_gap_pct = 6;
               recv_gap_pct = 56;
            end
            1: begin
               send_gap_pct = 56;
               recv_gap_pct = 6;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
            end
         endcase
         write_out_radix(segment_radix[seg]);
         if (seg == 0) begin
            // The largest value in binary gives the longest output, 64 digits. The
            // same digits followed by one binary digit in the same numeral wrap past
            // 64 bits.
            send_string("FFFFFFFFFFFFFFFF", rsc_pkg::RADIX_HEX);
            for (int i = 0; i < 16; i++)
               send_char(rsc_pkg::UPPER_OFFSET + 8'd15, rsc_pkg::RADIX_HEX, 1'b0);
            send_char(rsc_pkg::ASCII_ZERO, rsc_pkg::RADIX_BIN, 1'b1);
         end
         first_char = chars_sent;
         while (chars_sent - first_char < CHARS_PER_SEGMENT) send_random_numeral();
      end

      drain();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- radix_string_converter.f -----
+incdir+design
design/rsc_pkg.sv
design/rsc_channel_if.sv
design/rsc_front.sv
design/rsc_queue.sv
design/rsc_back.sv
design/radix_string_converter.sv
design/rsc_checker.sv
tb/sv/radix_string_converter_checker.sv
tb/sv/radix_string_converter_tb.sv
